// ----- hw/rtl/sspr_pkg.sv -----
package sspr_pkg;

    // Command codes of an input request.
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Transaction modes given with a start request.
    localparam logic [1:0] MODE_WRITE_ACK = 2'd0;
    localparam logic [1:0] MODE_PING      = 2'd1;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // Failure reasons.
    localparam logic [2:0] FAIL_NONE      = 3'd0;
    localparam logic [2:0] FAIL_NO_HEADER = 3'd1;
    localparam logic [2:0] FAIL_TIMEOUT   = 3'd2;
    localparam logic [2:0] FAIL_ID        = 3'd3;
    localparam logic [2:0] FAIL_LENGTH    = 3'd4;
    localparam logic [2:0] FAIL_CHECKSUM  = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_RESPONSE_LEVEL = 1'b0;
    localparam logic CFG_SEARCH_LIMIT   = 1'b1;

    // Protocol constants.
    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] BROADCAST_ID = 8'hFE;
    localparam logic [7:0] ACK_LENGTH   = 8'd2;
    localparam logic [7:0] LIMIT_RESET  = 8'd10;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] expected_id;
        logic [1:0] mode;
        logic [7:0] read_length;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] responder_id;
        logic [7:0] servo_status;
        logic [2:0] fail_reason;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

// ----- hw/rtl/sspr_in_if.sv -----
interface sspr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] expected_id;
    logic [1:0] mode;
    logic [7:0] read_length;
    logic [7:0] rx_byte;

    modport source (output valid, command, expected_id, mode, read_length, rx_byte,
                    input ready);
    modport sink (input valid, command, expected_id, mode, read_length, rx_byte,
                  output ready);
endinterface

// ----- hw/rtl/sspr_out_if.sv -----
interface sspr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] responder_id;
    logic [7:0] servo_status;
    logic [2:0] fail_reason;

    modport source (output valid, kind, data_byte, responder_id, servo_status, fail_reason,
                    input ready);
    modport sink (input valid, kind, data_byte, responder_id, servo_status, fail_reason,
                  output ready);
endinterface

// ----- hw/rtl/sspr_in_stage.sv -----
module sspr_in_stage
    import sspr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    sspr_in_if.sink  i_in,
    input  logic     i_adv,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    // The register takes a new request when empty or when its content moves on.
    assign i_in.ready = !r_valid || i_adv;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{command:     i_in.command,
                        expected_id: i_in.expected_id,
                        mode:        i_in.mode,
                        read_length: i_in.read_length,
                        rx_byte:     i_in.rx_byte};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/sspr_parser.sv -----
module sspr_parser
    import sspr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_adv,
    input  t_in_item   i_item,
    output t_result    o_res
);

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_HUNT   = 7'b0000010,
        PH_ID     = 7'b0000100,
        PH_LEN    = 7'b0001000,
        PH_STATUS = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_SUM    = 7'b1000000
    } t_phase;

    t_phase     r_phase,  n_phase;
    logic [1:0] r_mode,   n_mode;
    logic [7:0] r_target, n_target;
    logic [7:0] r_left,   n_left;
    logic [7:0] r_hunt,   n_hunt;
    logic       r_last_ff, n_last_ff;
    logic [7:0] r_sum,    n_sum;
    logic [7:0] r_got_id, n_got_id;
    logic [7:0] r_got_len, n_got_len;
    logic [7:0] r_got_status, n_got_status;
    logic       r_response_level;
    logic [7:0] r_search_limit;

    logic [7:0] sum_plus;
    logic [7:0] left_minus;
    logic       skip_id;
    t_result    res;

    assign sum_plus   = 8'(r_sum + i_item.rx_byte);
    assign left_minus = 8'(r_left - 8'd1);
    assign skip_id    = (r_mode == MODE_PING) && (r_target == BROADCAST_ID);

    // Next state and result for the request that moves on in this cycle.
    always_comb begin
        n_phase      = r_phase;
        n_mode       = r_mode;
        n_target     = r_target;
        n_left       = r_left;
        n_hunt       = r_hunt;
        n_last_ff    = r_last_ff;
        n_sum        = r_sum;
        n_got_id     = r_got_id;
        n_got_len    = r_got_len;
        n_got_status = r_got_status;
        res          = '0;

        unique case (i_item.command)
            CMD_START: begin
                n_mode       = i_item.mode;
                n_target     = i_item.expected_id;
                n_left       = i_item.read_length;
                n_hunt       = '0;
                n_last_ff    = 1'b0;
                n_sum        = '0;
                n_got_id     = '0;
                n_got_len    = '0;
                n_got_status = '0;
                // A write to broadcast, or with no replies configured, is done at once.
                if (i_item.mode == MODE_WRITE_ACK &&
                    (i_item.expected_id == BROADCAST_ID || !r_response_level)) begin
                    n_phase                = PH_IDLE;
                    res.valid              = 1'b1;
                    res.item.kind          = KIND_OK;
                    res.item.responder_id  = i_item.expected_id;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            CMD_BYTE: begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_item.rx_byte == HEADER_BYTE && r_last_ff) begin
                            n_phase = PH_ID;
                            n_sum   = '0;
                        end else begin
                            n_last_ff = (i_item.rx_byte == HEADER_BYTE);
                            if (r_hunt >= r_search_limit) begin
                                n_phase              = PH_IDLE;
                                res.valid            = 1'b1;
                                res.item.kind        = KIND_FAIL;
                                res.item.fail_reason = FAIL_NO_HEADER;
                            end else begin
                                n_hunt = 8'(r_hunt + 8'd1);
                            end
                        end
                    end
                    PH_ID: begin
                        n_got_id = i_item.rx_byte;
                        n_sum    = sum_plus;
                        n_phase  = PH_LEN;
                    end
                    PH_LEN: begin
                        n_got_len = i_item.rx_byte;
                        n_sum     = sum_plus;
                        n_phase   = PH_STATUS;
                    end
                    PH_STATUS: begin
                        n_got_status = i_item.rx_byte;
                        n_sum        = sum_plus;
                        n_phase      = (r_mode[1] && r_left != 8'd0) ? PH_DATA : PH_SUM;
                    end
                    PH_DATA: begin
                        n_sum  = sum_plus;
                        n_left = left_minus;
                        if (left_minus == 8'd0) begin
                            n_phase = PH_SUM;
                        end
                        res.valid          = 1'b1;
                        res.item.kind      = KIND_DATA;
                        res.item.data_byte = i_item.rx_byte;
                    end
                    PH_SUM: begin
                        n_phase   = PH_IDLE;
                        res.valid = 1'b1;
                        // Id first, then length, then checksum; reads skip the first two.
                        if (!r_mode[1] && !skip_id && r_got_id != r_target) begin
                            res.item.kind        = KIND_FAIL;
                            res.item.fail_reason = FAIL_ID;
                        end else if (!r_mode[1] && r_got_len != ACK_LENGTH) begin
                            res.item.kind        = KIND_FAIL;
                            res.item.fail_reason = FAIL_LENGTH;
                        end else if (~r_sum != i_item.rx_byte) begin
                            res.item.kind        = KIND_FAIL;
                            res.item.fail_reason = FAIL_CHECKSUM;
                        end else begin
                            res.item.kind         = KIND_OK;
                            res.item.responder_id = r_got_id;
                            res.item.servo_status = r_got_status;
                        end
                    end
                    default: begin
                        // Bytes while idle are dropped.
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            CMD_TIMEOUT: begin
                if (r_phase != PH_IDLE) begin
                    n_phase              = PH_IDLE;
                    res.valid            = 1'b1;
                    res.item.kind        = KIND_FAIL;
                    res.item.fail_reason = FAIL_TIMEOUT;
                end
            end
            CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_res = res;

    // Transaction state advances only when a request moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_mode       <= '0;
            r_target     <= '0;
            r_left       <= '0;
            r_hunt       <= '0;
            r_last_ff    <= 1'b0;
            r_sum        <= '0;
            r_got_id     <= '0;
            r_got_len    <= '0;
            r_got_status <= '0;
        end else if (i_adv) begin
            r_phase      <= n_phase;
            r_mode       <= n_mode;
            r_target     <= n_target;
            r_left       <= n_left;
            r_hunt       <= n_hunt;
            r_last_ff    <= n_last_ff;
            r_sum        <= n_sum;
            r_got_id     <= n_got_id;
            r_got_len    <= n_got_len;
            r_got_status <= n_got_status;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_level <= 1'b1;
            r_search_limit   <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESPONSE_LEVEL: r_response_level <= i_cfg_data[0];
                CFG_SEARCH_LIMIT:   r_search_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A data byte comes only out of the data phase.
    a_data_in_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && res.valid && res.item.kind == KIND_DATA |-> r_phase == PH_DATA)
        else $error("data byte emitted outside data phase");

    // Every failure closes the transaction.
    a_fail_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && res.valid && res.item.kind == KIND_FAIL |=> r_phase == PH_IDLE)
        else $error("transaction still open after failure");

    // Success comes from the checksum byte or an immediate acknowledge.
    a_ok_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && res.valid && res.item.kind == KIND_OK |->
            r_phase == PH_SUM || i_item.command == CMD_START)
        else $error("success reported from an unexpected phase");

endmodule

// ----- hw/rtl/sspr_out_stage.sv -----
module sspr_out_stage
    import sspr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    output logic      o_ok,
    sspr_out_if.source o_out
);

    logic      r_valid;
    t_out_item r_item;

    // A new result may be written when the register is empty or being drained.
    assign o_ok = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_item <= i_res.item;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_item.kind;
    assign o_out.data_byte    = r_item.data_byte;
    assign o_out.responder_id = r_item.responder_id;
    assign o_out.servo_status = r_item.servo_status;
    assign o_out.fail_reason  = r_item.fail_reason;

endmodule

// ----- hw/rtl/servo_status_packet_receiver_core.sv -----
// Servo status reply receiver.
// The input channel carries requests: start (expected id, mode, read length),
// a received byte, or a timeout. The output channel carries results: a read
// data byte, a success with responder id and servo status, or a failure with
// its reason. Most requests give no result; none gives more than one.
// Configuration is a plain write port: index 0 response level, index 1
// header search limit; write only while no request or result is in flight.
// A request is registered on acceptance and decoded through one stage of
// parse logic once the output register can take its result, which is then
// loaded into that register. One request per cycle is sustained while the
// output is ready; the rate is set by the single parse stage that updates
// the transaction state. When the receiver stalls, the pending result holds,
// one more request is kept in the input register and then input ready drops
// until the output drains. Synchronous active-low reset empties both registers,
// closes any transaction and restores response level 1 and search limit 10.
module servo_status_packet_receiver_core
    import sspr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    sspr_in_if.sink    i_in,
    sspr_out_if.source o_out
);

    logic     in_valid;
    t_in_item in_item;
    logic     out_ok;
    logic     adv;
    t_result  res;

    // The registered request moves on when the output register can take its result.
    assign adv = in_valid && out_ok;

    sspr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    sspr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (adv),
        .i_item      (in_item),
        .o_res       (res)
    );

    sspr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (res),
        .o_ok    (out_ok),
        .o_out   (o_out)
    );

endmodule
